[design/queue_record_crc_deframer_core_macros.svh]
// ----------------------------------------------------------------------------
// Queue record CRC deframer assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef QUEUE_RECORD_CRC_DEFRAMER_CORE_MACROS_SVH
`define QUEUE_RECORD_CRC_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication
`define QRCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qrcd assertion failed");

// next-cycle implication
`define QRCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qrcd assertion failed");

`endif

[design/qrcd_pkg.sv]
// ----------------------------------------------------------------------------
// qrcd_pkg
// Shared types, constants and functions of the queue record CRC deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qrcd_pkg;

  localparam int unsigned HdrBytes   = 52;
  localparam int unsigned FixedBytes = 56;
  localparam int unsigned CountW     = 10;
  localparam int unsigned LenW       = CountW + 1;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  localparam logic [CountW-1:0] PosCrcStart = CountW'(4);
  localparam logic [CountW-1:0] PosPayload  = CountW'(HdrBytes);
  localparam logic [LenW-1:0]   LenFixed    = LenW'(FixedBytes);

  typedef enum logic [1:0] {
    CFG_MAGIC    = 2'd0,
    CFG_VERSION  = 2'd1,
    CFG_CAPACITY = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] enc_len;
    logic [63:0] record_id;
    logic [7:0]  flags;
    logic [7:0]  pay_len;
    logic [15:0] pkt_len;
    logic [31:0] boot;
    logic [63:0] received;
    logic [63:0] uptime;
    logic [31:0] rssi;
    logic [31:0] snr;
    logic [31:0] freq;
  } hdr_t;

  typedef struct packed {
    logic [CountW-1:0] pos;
    logic [31:0]       crc;
    logic [31:0]       window;
    hdr_t              hdr;
  } rec_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [7:0]  capacity;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        ok;
    logic [63:0] record_id;
    logic        time_trusted;
    logic [7:0]  payload_length;
    logic [31:0] boot;
    logic [63:0] received;
    logic [63:0] uptime;
    logic [31:0] rssi;
    logic [31:0] snr;
    logic [31:0] freq;
  } res_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc_in, logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic hdr_t capture(hdr_t h_in, logic [CountW-1:0] pos, logic [7:0] b);
    hdr_t h;
    h = h_in;
    priority if (pos < CountW'(4))  h.magic     = {h.magic[23:0], b};
    else if (pos < CountW'(6))      h.version   = {h.version[7:0], b};
    else if (pos < CountW'(8))      h.enc_len   = {h.enc_len[7:0], b};
    else if (pos < CountW'(16))     h.record_id = {h.record_id[55:0], b};
    else if (pos < CountW'(17))     h.flags     = b;
    else if (pos < CountW'(18))     h.pay_len   = b;
    else if (pos < CountW'(20))     h.pkt_len   = {h.pkt_len[7:0], b};
    else if (pos < CountW'(24))     h.boot      = {h.boot[23:0], b};
    else if (pos < CountW'(32))     h.received  = {h.received[55:0], b};
    else if (pos < CountW'(40))     h.uptime    = {h.uptime[55:0], b};
    else if (pos < CountW'(44))     h.rssi      = {h.rssi[23:0], b};
    else if (pos < CountW'(48))     h.snr       = {h.snr[23:0], b};
    else if (pos < CountW'(52))     h.freq      = {h.freq[23:0], b};
    else                            h           = h_in;
    return h;
  endfunction

endpackage

[design/queue_record_crc_deframer_core.sv]
// ----------------------------------------------------------------------------
// queue_record_crc_deframer_core
// Checked queue record deframer with CRC-32 and header validation.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o) carries one record byte per
//   transfer, last_byte_i set on the final byte. The output channel
//   (out_valid_o/out_ready_i) returns a tentative payload byte (kind_o 0) for
//   each payload byte and one status (kind_o 1) on the final byte; header
//   fields are zero unless record_ok_o is set. The configuration channel
//   (cfg_valid_i/cfg_ready_o) writes magic, version and payload capacity by
//   index and is always ready; write it only while the block is idle.
//   CRC step, header capture and checks sit between the frame state
//   registers and the output register, so a result appears in the cycle
//   after its input transfer and one byte can be taken every cycle while
//   the receiver keeps up. While the output register holds a result the
//   receiver has not taken, in_ready_o drops. Reset clears the record state,
//   sets the CRC to all ones, capacity to 255 and magic and version to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module queue_record_crc_deframer_core import qrcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [7:0]         payload_byte_o,
  output logic               record_ok_o,
  output logic [63:0]        record_id_o,
  output logic               time_trusted_o,
  output logic [7:0]         payload_length_o,
  output logic [31:0]        boot_session_o,
  output logic signed [63:0] received_ms_o,
  output logic [63:0]        uptime_ms_o,
  output logic [31:0]        rssi_bits_o,
  output logic [31:0]        snr_bits_o,
  output logic signed [31:0] freq_error_o
);

  `include "queue_record_crc_deframer_core_macros.svh"

  cfg_t       cfg_q;
  rec_t       rec;
  res_t       res, res_q;
  logic       emit;
  logic       in_xfer;
  logic       out_valid_q;
  cfg_index_e cfg_idx;

  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = cfg_index_e'(cfg_index_i);
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic    <= '0;
      cfg_q.version  <= '0;
      cfg_q.capacity <= 8'd255;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx)
        CFG_MAGIC:    cfg_q.magic    <= cfg_data_i;
        CFG_VERSION:  cfg_q.version  <= cfg_data_i[15:0];
        CFG_CAPACITY: cfg_q.capacity <= cfg_data_i[7:0];
        default:      ;
      endcase
    end
  end

  qrcd_frame_state u_frame_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_xfer),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .rec_o       (rec)
  );

  qrcd_status_check u_status_check (
    .rec_i       (rec),
    .cfg_i       (cfg_q),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .emit_o      (emit),
    .res_o       (res)
  );

  // hold result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = res_q.kind;
  assign payload_byte_o   = res_q.payload_byte;
  assign record_ok_o      = res_q.ok;
  assign record_id_o      = res_q.record_id;
  assign time_trusted_o   = res_q.time_trusted;
  assign payload_length_o = res_q.payload_length;
  assign boot_session_o   = res_q.boot;
  assign received_ms_o    = res_q.received;
  assign uptime_ms_o      = res_q.uptime;
  assign rssi_bits_o      = res_q.rssi;
  assign snr_bits_o       = res_q.snr;
  assign freq_error_o     = res_q.freq;

  `QRCD_ASSERT_NEXT(a_last_gives_status, in_xfer && last_byte_i, out_valid_o && kind_o)
  `QRCD_ASSERT_NOW(a_payload_not_ok, out_valid_o && !kind_o, !record_ok_o && record_id_o == '0)
  `QRCD_ASSERT_NOW(a_fail_zero_id, out_valid_o && kind_o && !record_ok_o, record_id_o == '0)
  `QRCD_ASSERT_NOW(a_ok_has_length, out_valid_o && record_ok_o, payload_length_o != '0)

endmodule

[design/qrcd_frame_state.sv]
// ----------------------------------------------------------------------------
// qrcd_frame_state
// Byte counter, delayed CRC, tail window and header capture of one record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrcd_frame_state import qrcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output rec_t       rec_o
);

  rec_t rec_q, rec_d;

  always_comb begin
    rec_d.pos    = (rec_q.pos == CountMax) ? rec_q.pos : rec_q.pos + CountW'(1);
    rec_d.crc    = (rec_q.pos >= PosCrcStart) ? crc_byte(rec_q.crc, rec_q.window[31:24])
                                              : rec_q.crc;
    rec_d.window = {rec_q.window[23:0], data_byte_i};
    rec_d.hdr    = capture(rec_q.hdr, rec_q.pos, data_byte_i);
  end

  // view after this byte, position of this byte
  always_comb begin
    rec_o     = rec_d;
    rec_o.pos = rec_q.pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q     <= '0;
      rec_q.crc <= CrcInit;
    end else if (accept_i) begin
      if (last_byte_i) begin
        rec_q     <= '0;
        rec_q.crc <= CrcInit;
      end else begin
        rec_q <= rec_d;
      end
    end
  end

endmodule

[design/qrcd_status_check.sv]
// ----------------------------------------------------------------------------
// qrcd_status_check
// Payload window decision and end-of-record validity checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrcd_status_check import qrcd_pkg::*; (
  input  rec_t       rec_i,
  input  cfg_t       cfg_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       emit_o,
  output res_t       res_o
);

  logic [LenW-1:0]   length;
  logic [CountW-1:0] pay_off;
  logic              in_window;
  logic              time_ok;
  logic              ok;
  hdr_t              h;

  assign h         = rec_i.hdr;
  assign length    = {1'b0, rec_i.pos} + LenW'(1);
  assign pay_off   = rec_i.pos - PosPayload;
  assign in_window = (rec_i.pos >= PosPayload) && (pay_off < {2'b00, h.pay_len});
  assign time_ok   = (h.flags == 8'd1) ? !h.received[63] : (h.received == '1);

  assign ok = (length >= LenFixed)
           && (length <= LenFixed + {3'b000, cfg_i.capacity})
           && (h.magic == cfg_i.magic)
           && (h.version == cfg_i.version)
           && (h.enc_len == {5'd0, length})
           && (h.record_id != '0)
           && (h.flags <= 8'd1)
           && (h.pay_len != '0)
           && (h.pay_len <= cfg_i.capacity)
           && (h.pkt_len == {8'd0, h.pay_len})
           && (length == LenFixed + {3'b000, h.pay_len})
           && time_ok
           && (rec_i.window == ~rec_i.crc);

  assign emit_o = last_byte_i || in_window;

  always_comb begin
    res_o = '0;
    if (last_byte_i) begin
      res_o.kind = 1'b1;
      if (ok) begin
        res_o.ok             = 1'b1;
        res_o.record_id      = h.record_id;
        res_o.time_trusted   = (h.flags == 8'd1);
        res_o.payload_length = h.pay_len;
        res_o.boot           = h.boot;
        res_o.received       = h.received;
        res_o.uptime         = h.uptime;
        res_o.rssi           = h.rssi;
        res_o.snr            = h.snr;
        res_o.freq           = h.freq;
      end
    end else begin
      res_o.payload_byte = data_byte_i;
    end
  end

endmodule

[tb/sv/queue_record_crc_deframer_core_tb.sv]
// ----------------------------------------------------------------------------
// queue_record_crc_deframer_core_tb
// Self-checking bench for the queue record deframer. Builds records with a
// correct or deliberately broken header, length or CRC, streams them byte by
// byte under random source bursts and sink stalls, and compares every
// tentative payload byte and every status against a bytewise predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module queue_record_crc_deframer_core_tb;
  import qrcd_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned RandomBytes = 600;
  localparam int unsigned SweepPhases = 6;

  typedef enum int {
    FAULT_NONE,
    FAULT_MAGIC,
    FAULT_VERSION,
    FAULT_ENC_LEN,
    FAULT_ZERO_ID,
    FAULT_FLAGS,
    FAULT_ZERO_PAYLOAD,
    FAULT_OVER_CAPACITY,
    FAULT_PKT_LEN,
    FAULT_SIZE,
    FAULT_TIME_NEG,
    FAULT_TIME_UNTRUSTED,
    FAULT_CRC,
    FAULT_SHORT,
    FAULT_NOISE
  } fault_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] enc_len;
    logic [63:0] record_id;
    logic [7:0]  flags;
    logic [7:0]  pay_len;
    logic [15:0] pkt_len;
    logic [31:0] boot;
    logic [63:0] received;
    logic [63:0] uptime;
    logic [31:0] rssi;
    logic [31:0] snr;
    logic [31:0] freq;
  } frame_hdr_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i    = CFG_MAGIC;
  logic [31:0]        cfg_data_i     = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i    = '0;
  logic               last_byte_i    = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic               kind_o;
  logic [7:0]         payload_byte_o;
  logic               record_ok_o;
  logic [63:0]        record_id_o;
  logic               time_trusted_o;
  logic [7:0]         payload_length_o;
  logic [31:0]        boot_session_o;
  logic signed [63:0] received_ms_o;
  logic [63:0]        uptime_ms_o;
  logic [31:0]        rssi_bits_o;
  logic [31:0]        snr_bits_o;
  logic signed [31:0] freq_error_o;

  queue_record_crc_deframer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .payload_byte_o   (payload_byte_o),
    .record_ok_o      (record_ok_o),
    .record_id_o      (record_id_o),
    .time_trusted_o   (time_trusted_o),
    .payload_length_o (payload_length_o),
    .boot_session_o   (boot_session_o),
    .received_ms_o    (received_ms_o),
    .uptime_ms_o      (uptime_ms_o),
    .rssi_bits_o      (rssi_bits_o),
    .snr_bits_o       (snr_bits_o),
    .freq_error_o     (freq_error_o)
  );

  always #10 clk_i = ~clk_i;

  // register image
  logic [31:0] want_magic   = '0;
  logic [15:0] want_version = '0;
  logic [7:0]  capacity     = 8'd255;

  // receive-side record state
  int unsigned rx_count;
  logic [31:0] rx_crc;
  logic [7:0]  rx_tail [4];
  frame_hdr_t  rx_hdr;

  res_t        pending [$];
  res_t        want;
  logic [7:0]  frame_q [$];

  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned frames_sent   = 0;
  int unsigned statuses_seen = 0;
  int unsigned passes_seen   = 0;
  int unsigned payload_seen  = 0;
  int unsigned burst_left    = 0;
  logic        steady_send   = 1'b0;
  logic [2:0]  sink_mode     = '0;
  logic [7:0]  sink_count    = '0;

  function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void clear_frame_state();
    rx_count = 0;
    rx_crc   = CrcInit;
    rx_tail  = '{default: '0};
    rx_hdr   = '0;
  endfunction

  function automatic void capture_header(int unsigned pos, logic [7:0] b);
    if (pos < 4)       rx_hdr.magic     = {rx_hdr.magic[23:0], b};
    else if (pos < 6)  rx_hdr.version   = {rx_hdr.version[7:0], b};
    else if (pos < 8)  rx_hdr.enc_len   = {rx_hdr.enc_len[7:0], b};
    else if (pos < 16) rx_hdr.record_id = {rx_hdr.record_id[55:0], b};
    else if (pos < 17) rx_hdr.flags     = b;
    else if (pos < 18) rx_hdr.pay_len   = b;
    else if (pos < 20) rx_hdr.pkt_len   = {rx_hdr.pkt_len[7:0], b};
    else if (pos < 24) rx_hdr.boot      = {rx_hdr.boot[23:0], b};
    else if (pos < 32) rx_hdr.received  = {rx_hdr.received[55:0], b};
    else if (pos < 40) rx_hdr.uptime    = {rx_hdr.uptime[55:0], b};
    else if (pos < 44) rx_hdr.rssi      = {rx_hdr.rssi[23:0], b};
    else if (pos < 48) rx_hdr.snr       = {rx_hdr.snr[23:0], b};
    else if (pos < 52) rx_hdr.freq      = {rx_hdr.freq[23:0], b};
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic last);
    int unsigned pos;
    int unsigned len;
    logic [31:0] stored;
    logic        trusted;
    logic        pass;
    res_t        r;
    pos = rx_count;
    if (pos >= 4) rx_crc = crc32_step(rx_crc, rx_tail[0]);
    rx_tail[0] = rx_tail[1];
    rx_tail[1] = rx_tail[2];
    rx_tail[2] = rx_tail[3];
    rx_tail[3] = b;
    capture_header(pos, b);
    if (rx_count < CountMax) rx_count++;
    r = '0;
    if (!last) begin
      if (pos >= HdrBytes && pos - HdrBytes < rx_hdr.pay_len) begin
        r.payload_byte = b;
        pending = {pending, r};
      end
      return;
    end
    len     = pos + 1;
    stored  = {rx_tail[0], rx_tail[1], rx_tail[2], rx_tail[3]};
    trusted = (rx_hdr.flags == 8'd1);
    pass    = len >= FixedBytes && len <= FixedBytes + capacity &&
              rx_hdr.magic == want_magic && rx_hdr.version == want_version &&
              rx_hdr.enc_len == len && rx_hdr.record_id != '0 &&
              rx_hdr.flags <= 8'd1 && rx_hdr.pay_len != '0 &&
              rx_hdr.pay_len <= capacity && rx_hdr.pkt_len == rx_hdr.pay_len &&
              len == FixedBytes + rx_hdr.pay_len &&
              (trusted ? !rx_hdr.received[63] : (rx_hdr.received == '1)) &&
              stored == ~rx_crc;
    r.kind = 1'b1;
    if (pass) begin
      r.ok             = 1'b1;
      r.record_id      = rx_hdr.record_id;
      r.time_trusted   = trusted;
      r.payload_length = rx_hdr.pay_len;
      r.boot           = rx_hdr.boot;
      r.received       = rx_hdr.received;
      r.uptime         = rx_hdr.uptime;
      r.rssi           = rx_hdr.rssi;
      r.snr            = rx_hdr.snr;
      r.freq           = rx_hdr.freq;
    end
    pending = {pending, r};
    clear_frame_state();
  endfunction

  function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending.size() == 0) begin
        $error("result with nothing pending: kind %0d", kind_o);
        mismatches++;
      end else begin
        want = pending.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("payload_byte", want.payload_byte, payload_byte_o);
        check_field("record_ok", want.ok, record_ok_o);
        check_field("record_id", want.record_id, record_id_o);
        check_field("time_trusted", want.time_trusted, time_trusted_o);
        check_field("payload_length", want.payload_length, payload_length_o);
        check_field("boot_session", want.boot, boot_session_o);
        check_field("received_ms", want.received, $unsigned(received_ms_o));
        check_field("uptime_ms", want.uptime, uptime_ms_o);
        check_field("rssi_bits", want.rssi, rssi_bits_o);
        check_field("snr_bits", want.snr, snr_bits_o);
        check_field("freq_error", want.freq, $unsigned(freq_error_o));
        if (want.kind) statuses_seen++;
        else payload_seen++;
        if (want.ok) passes_seen++;
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) predict_byte(data_byte_i, last_byte_i);
  end

  // sink: always ready, coin flip, mostly stalled, or a fixed duty pattern
  always @(posedge clk_i) begin
    sink_count <= sink_count + 8'd1;
    if (sink_count == '0) sink_mode <= 3'($urandom_range(0, 3));
    case (sink_mode)
      3'd0:    out_ready_i <= 1'b1;
      3'd1:    out_ready_i <= 1'($urandom_range(0, 1));
      3'd2:    out_ready_i <= ($urandom_range(0, 4) == 0);
      default: out_ready_i <= (sink_count[2:0] < 3'd5);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $error("timeout after %0d cycles, %0d results pending", cycle_count, pending.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      while (gap > 0) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        gap--;
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  // drain outstanding results, then hold off for the pipeline tail
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_MAGIC:    want_magic   = data;
      CFG_VERSION:  want_version = data[15:0];
      CFG_CAPACITY: capacity     = data[7:0];
      default:      ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void push_be(logic [63:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) frame_q = {frame_q, v[8*i +: 8]};
  endfunction

  function automatic void build_frame(frame_hdr_t h, int unsigned n, logic [31:0] crc_err);
    logic [31:0] crc;
    frame_q.delete();
    push_be(h.magic, 4);
    push_be(h.version, 2);
    push_be(h.enc_len, 2);
    push_be(h.record_id, 8);
    push_be(h.flags, 1);
    push_be(h.pay_len, 1);
    push_be(h.pkt_len, 2);
    push_be(h.boot, 4);
    push_be(h.received, 8);
    push_be(h.uptime, 8);
    push_be(h.rssi, 4);
    push_be(h.snr, 4);
    push_be(h.freq, 4);
    repeat (n) frame_q = {frame_q, 8'($urandom)};
    crc = CrcInit;
    foreach (frame_q[i]) crc = crc32_step(crc, frame_q[i]);
    push_be(~crc ^ crc_err, 4);
  endfunction

  function automatic frame_hdr_t good_header(int unsigned n, logic trusted);
    frame_hdr_t h;
    h.magic     = want_magic;
    h.version   = want_version;
    h.enc_len   = 16'(FixedBytes + n);
    h.record_id = {$urandom, $urandom};
    if (h.record_id == '0) h.record_id = 64'd1;
    h.flags     = {7'd0, trusted};
    h.pay_len   = 8'(n);
    h.pkt_len   = 16'(n);
    h.boot      = $urandom;
    h.received  = trusted ? {1'b0, 31'($urandom), 32'($urandom)} : '1;
    h.uptime    = {$urandom, $urandom};
    h.rssi      = $urandom;
    h.snr       = $urandom;
    h.freq      = $urandom;
    return h;
  endfunction

  task automatic send_record(fault_e f);
    frame_hdr_t  h;
    int unsigned span;
    int unsigned n;
    logic [31:0] crc_err;
    span    = (capacity == 0) ? 8 : capacity;
    n       = ($urandom_range(0, 4) != 0) ? $urandom_range(1, (span < 12) ? span : 12)
                                          : $urandom_range(1, span);
    h       = good_header(n, 1'($urandom_range(0, 1)));
    crc_err = '0;
    case (f)
      FAULT_MAGIC:   h.magic   ^= 32'(1) << $urandom_range(0, 31);
      FAULT_VERSION: h.version ^= 16'(1) << $urandom_range(0, 15);
      FAULT_ENC_LEN: h.enc_len ^= 16'(1) << $urandom_range(0, 15);
      FAULT_ZERO_ID: h.record_id = '0;
      FAULT_FLAGS:   h.flags = 8'($urandom_range(2, 255));
      FAULT_ZERO_PAYLOAD: begin
        n         = 0;
        h.pay_len = '0;
        h.pkt_len = '0;
        h.enc_len = 16'(FixedBytes);
      end
      FAULT_OVER_CAPACITY: begin
        if (capacity < 8'd255) begin
          n         = $urandom_range(int'(capacity) + 1, 255);
          h.pay_len = 8'(n);
          h.pkt_len = 16'(n);
          h.enc_len = 16'(FixedBytes + n);
        end else begin
          h.record_id = '0;
        end
      end
      FAULT_PKT_LEN: h.pkt_len ^= 16'(1) << $urandom_range(0, 15);
      FAULT_SIZE: begin
        n         = $urandom_range(0, 1) ? n + 1 : n - 1;
        h.enc_len = 16'(FixedBytes + n);
      end
      FAULT_TIME_NEG: begin
        h.flags        = 8'd1;
        h.received[63] = 1'b1;
      end
      FAULT_TIME_UNTRUSTED: begin
        h.flags    = 8'd0;
        h.received = {$urandom, $urandom};
        if (h.received == '1) h.received[0] = 1'b0;
      end
      FAULT_CRC: crc_err = 32'(1) << $urandom_range(0, 31);
      default: ;
    endcase
    if (f == FAULT_SHORT || f == FAULT_NOISE) begin
      frame_q.delete();
      repeat ($urandom_range(1, (f == FAULT_SHORT) ? FixedBytes - 1 : 120)) begin
        frame_q = {frame_q, 8'($urandom)};
      end
    end else begin
      build_frame(h, n, crc_err);
    end
    send_frame();
  endtask

  task automatic test_reset_config();
    frame_hdr_t h;
    h          = good_header(1, 1'b1);
    h.received = '0;
    h.boot     = '0;
    h.uptime   = '0;
    h.rssi     = '0;
    h.snr      = '0;
    h.freq     = 32'h8000_0000;
    build_frame(h, 1, '0);
    send_frame();
    h           = good_header(255, 1'b0);
    h.record_id = '1;
    h.boot      = '1;
    h.uptime    = '1;
    h.rssi      = '1;
    h.snr       = '1;
    h.freq      = 32'h7FFF_FFFF;
    build_frame(h, 255, '0);
    send_frame();
    h          = good_header(3, 1'b1);
    h.received = 64'h7FFF_FFFF_FFFF_FFFF;
    build_frame(h, 3, '0);
    send_frame();
    settle();
  endtask

  task automatic test_header_checks();
    write_reg(CFG_MAGIC, $urandom);
    write_reg(CFG_VERSION, $urandom);
    for (int f = FAULT_NONE; f <= FAULT_NOISE; f++) send_record(fault_e'(f));
    settle();
  endtask

  task automatic test_frame_length();
    frame_hdr_t h;
    frame_q.delete();
    frame_q = {frame_q, 8'hFF};
    send_frame();
    frame_q.delete();
    repeat (FixedBytes - 1) frame_q = {frame_q, 8'($urandom)};
    send_frame();
    // overlong record saturates the byte count
    h = good_header(255, 1'b1);
    build_frame(h, 1100 - FixedBytes, '0);
    send_frame();
    send_record(FAULT_NONE);
    settle();
  endtask

  task automatic test_capacity_limits();
    write_reg(CFG_CAPACITY, 32'd1);
    send_record(FAULT_NONE);
    send_record(FAULT_OVER_CAPACITY);
    settle();
    write_reg(CFG_CAPACITY, 32'd0);
    send_record(FAULT_NONE);
    send_record(FAULT_ZERO_PAYLOAD);
    settle();
    write_reg(CFG_UNUSED, $urandom);
    write_reg(CFG_CAPACITY, {24'($urandom), 8'd255});
    send_record(FAULT_NONE);
    settle();
  endtask

  task automatic test_random_sweep();
    int unsigned phase_start;
    int unsigned pick;
    logic [31:0] magic_v;
    logic [15:0] version_v;
    logic [7:0]  cap_v;
    for (int p = 0; p < SweepPhases; p++) begin
      magic_v   = $urandom;
      version_v = 16'($urandom);
      case (p)
        0: begin
          magic_v   = '1;
          version_v = '1;
          cap_v     = 8'd255;
        end
        1: begin
          magic_v   = '0;
          version_v = '0;
          cap_v     = 8'd1;
        end
        2:       cap_v = 8'($urandom_range(2, 254));
        3:       cap_v = 8'd0;
        4:       cap_v = 8'd255;
        default: cap_v = 8'($urandom_range(1, 16));
      endcase
      write_reg(CFG_MAGIC, magic_v);
      write_reg(CFG_VERSION, {16'($urandom), version_v});
      write_reg(CFG_CAPACITY, {24'($urandom), cap_v});
      if (p == 2) write_reg(CFG_UNUSED, $urandom);
      steady_send = (p % 3 == 0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RandomBytes / SweepPhases) begin
        pick = $urandom_range(0, 34);
        send_record((pick <= FAULT_NOISE) ? fault_e'(pick) : FAULT_NONE);
      end
      settle();
    end
  endtask

  initial begin
    clear_frame_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_header_checks();
    test_frame_length();
    test_capacity_limits();
    test_random_sweep();
    if (pending.size() != 0) begin
      $error("%0d results never arrived", pending.size());
      mismatches++;
    end
    $display("%0d records in %0d bytes: %0d statuses (%0d passing), %0d payload bytes",
             frames_sent, bytes_sent, statuses_seen, passes_seen, payload_seen);
    $display("every header check, short and saturated lengths, capacity 0/1/255 and random");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/qrcd_pkg.sv
design/qrcd_frame_state.sv
design/qrcd_status_check.sv
design/queue_record_crc_deframer_core.sv
tb/sv/queue_record_crc_deframer_core_tb.sv
